@@ hw/rtl/ehp_pkg.sv @@
// Shared types and constants for the Ethernet/IP header parser.
`timescale 1ns / 1ps
`default_nettype none
package ehp_pkg;

	// Frame layout.
	localparam logic [15:0] ETH_HDR      = 16'd14;
	localparam logic [15:0] IPV4_MIN_LEN = 16'd34;
	localparam logic [15:0] IPV6_MIN_LEN = 16'd54;
	localparam logic [15:0] POS_ETYPE_HI = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO = 16'd13;
	localparam logic [15:0] POS_IHL      = 16'd14;
	localparam logic [15:0] POS_PROTO6   = 16'd20;
	localparam logic [15:0] POS_PROTO4   = 16'd23;
	localparam logic [15:0] POS_ADDR_LO  = 16'd22;
	localparam logic [15:0] POS_ADDR_HI  = 16'd53;
	localparam logic [6:0]  IPV6_TOFF    = 7'd54;
	localparam logic [6:0]  ETH_HDR_TOFF = 7'd14;
	localparam logic [3:0]  IHL_MASK     = 4'hF;
	localparam logic [7:0]  TCP_HDR_LEN  = 8'd20;
	localparam logic [7:0]  UDP_HDR_LEN  = 8'd8;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	// Register reset values.
	localparam logic [15:0] MAX_FRAME_LEN_RST  = 16'd1500;
	localparam logic [15:0] OVERSIZE_LIMIT_RST = 16'd100;

	// Register indexes (word address bit 2).
	typedef enum logic {
		REG_MAX_FRAME_LEN  = 1'b0,
		REG_OVERSIZE_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		VERDICT_PASS      = 3'd0,
		VERDICT_RUNT      = 3'd1,
		VERDICT_OVERSIZE  = 3'd2,
		VERDICT_NOT_IP    = 3'd3,
		VERDICT_TRUNCATED = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		IP_NONE = 2'd0,
		IP_V4   = 2'd1,
		IP_V6   = 2'd2
	} ip_kind_t;

	typedef enum logic [1:0] {
		TRANS_NONE = 2'd0,
		TRANS_TCP  = 2'd1,
		TRANS_UDP  = 2'd2
	} trans_kind_t;

	// Configuration seen by the verdict stage.
	typedef struct packed {
		logic [15:0] max_frame_len;
		logic [15:0] oversize_limit;
	} cfg_t;

	// Header fields captured from the current frame.
	typedef struct packed {
		logic [15:0]  etype;
		logic [6:0]   toff;
		logic [7:0]   proto4;
		logic [7:0]   proto6;
		logic [255:0] addr;
		logic [31:0]  ports;
	} hdr_fields_t;

	// End-of-frame notice from the capture stage.
	typedef struct packed {
		logic        done;
		logic [15:0] len;
	} frame_end_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  verdict;
		logic [1:0]  ip_kind;
		logic [1:0]  transport_kind;
		logic [31:0] frame_id;
		logic [63:0] src_addr_high;
		logic [63:0] src_addr_low;
		logic [63:0] dst_addr_high;
		logic [63:0] dst_addr_low;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] frame_length;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/ehp_if.sv @@
// Byte input and result output channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface ehp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ehp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [1:0]  ip_kind;
	logic [1:0]  transport_kind;
	logic [31:0] frame_id;
	logic [63:0] src_addr_high;
	logic [63:0] src_addr_low;
	logic [63:0] dst_addr_high;
	logic [63:0] dst_addr_low;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [15:0] frame_length;

	modport source (output valid, verdict, ip_kind, transport_kind, frame_id,
		src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
		src_port, dst_port, frame_length, input ready);
	modport sink (input valid, verdict, ip_kind, transport_kind, frame_id,
		src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
		src_port, dst_port, frame_length, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ehp_regs.sv @@
// APB-style configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module ehp_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output ehp_pkg::cfg_t    cfg
);

	ehp_pkg::cfg_t     cfg_q;
	ehp_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = ehp_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_frame_len  <= ehp_pkg::MAX_FRAME_LEN_RST;
			cfg_q.oversize_limit <= ehp_pkg::OVERSIZE_LIMIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				ehp_pkg::REG_MAX_FRAME_LEN:  cfg_q.max_frame_len  <= pwdata[15:0];
				ehp_pkg::REG_OVERSIZE_LIMIT: cfg_q.oversize_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (idx)
			ehp_pkg::REG_MAX_FRAME_LEN:  prdata = {16'b0, cfg_q.max_frame_len};
			ehp_pkg::REG_OVERSIZE_LIMIT: prdata = {16'b0, cfg_q.oversize_limit};
			default:                     prdata = 32'b0;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/ehp_capture.sv @@
// Byte counter and header field capture for the frame in progress.
`timescale 1ns / 1ps
`default_nettype none
module ehp_capture #(
	parameter int unsigned MAX_FRAME_BYTES = 65535
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output ehp_pkg::hdr_fields_t  fields,
	output ehp_pkg::frame_end_t   frame_end
);

	logic [15:0] count_q;
	logic [15:0] count_inc;
	logic [15:0] etype_q;
	logic [6:0]  toff_q;
	logic [6:0]  toff_calc;
	logic [6:0]  toff_now;
	logic [7:0]  proto4_q;
	logic [7:0]  proto6_q;
	logic [7:0]  addr_q [32];
	logic [7:0]  port_q [4];
	logic [15:0] addr_off;
	logic        addr_hit;

	// Saturating byte count; the count after this beat is the frame length.
	assign count_inc = (count_q < 16'(MAX_FRAME_BYTES)) ? count_q + 16'd1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd0;
		end else if (accept) begin
			count_q <= last_byte ? 16'd0 : count_inc;
		end
	end

	assign frame_end.done = accept & last_byte;
	assign frame_end.len  = count_inc;

	// Transport offset; at the IHL byte itself it comes straight from the beat.
	assign toff_calc = (etype_q == ehp_pkg::ETYPE_IPV6) ? ehp_pkg::IPV6_TOFF :
		ehp_pkg::ETH_HDR_TOFF + {1'b0, data_byte[3:0] & ehp_pkg::IHL_MASK, 2'b00};
	assign toff_now  = (count_q == ehp_pkg::POS_IHL) ? toff_calc : toff_q;

	assign addr_off = count_q - ehp_pkg::POS_ADDR_LO;
	assign addr_hit = (count_q >= ehp_pkg::POS_ADDR_LO) && (count_q <= ehp_pkg::POS_ADDR_HI);

	// Field capture at fixed byte positions, and ports at the transport offset.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (count_q == ehp_pkg::POS_ETYPE_HI) etype_q[15:8] <= data_byte;
			if (count_q == ehp_pkg::POS_ETYPE_LO) etype_q[7:0]  <= data_byte;
			if (count_q == ehp_pkg::POS_IHL)      toff_q        <= toff_calc;
			if (count_q == ehp_pkg::POS_PROTO4)   proto4_q      <= data_byte;
			if (count_q == ehp_pkg::POS_PROTO6)   proto6_q      <= data_byte;
			if (addr_hit)                         addr_q[addr_off[4:0]] <= data_byte;
			for (int k = 0; k < 4; k++) begin
				if (count_q == {9'b0, toff_now} + 16'(k)) port_q[k] <= data_byte;
			end
		end
	end

	// Pack captured bytes big-endian.
	always_comb begin
		fields.etype  = etype_q;
		fields.toff   = toff_q;
		fields.proto4 = proto4_q;
		fields.proto6 = proto6_q;
		for (int i = 0; i < 32; i++) begin
			fields.addr[255 - 8 * i -: 8] = addr_q[i];
		end
		for (int k = 0; k < 4; k++) begin
			fields.ports[31 - 8 * k -: 8] = port_q[k];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ehp_verdict.sv @@
// Verdict stage: frame and oversize counters, result build and output register.
`timescale 1ns / 1ps
`default_nettype none
module ehp_verdict (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ehp_pkg::cfg_t        cfg,
	input  wire ehp_pkg::hdr_fields_t fields,
	input  wire ehp_pkg::frame_end_t  frame_end,
	output logic                      in_ready,
	ehp_result_if.source              tx
);

	logic              end_s1;
	logic [15:0]       len_s1;
	logic [31:0]       frame_cnt_q;
	logic [31:0]       ovs_cnt_q;
	logic [31:0]       ovs_inc;
	logic              out_valid_q;
	ehp_pkg::result_t  out_q;
	ehp_pkg::result_t  res;
	logic              move;
	logic              runt;
	logic              oversize;
	logic              drop;
	logic [7:0]        proto;
	logic [15:0]       toff16;

	assign move     = !out_valid_q || tx.ready;
	assign in_ready = !end_s1 || move;

	assign runt     = len_s1 < ehp_pkg::ETH_HDR;
	assign oversize = len_s1 > cfg.max_frame_len;
	assign ovs_inc  = (ovs_cnt_q == 32'hFFFF_FFFF) ? ovs_cnt_q : ovs_cnt_q + 32'd1;
	assign drop     = oversize && (ovs_inc > {16'b0, cfg.oversize_limit});
	assign toff16   = {9'b0, fields.toff};

	// Build the result for the frame that just ended.
	always_comb begin
		res              = '0;
		res.frame_length = len_s1;
		proto            = 8'd0;
		if (runt) begin
			res.verdict = ehp_pkg::VERDICT_RUNT;
		end else begin
			res.frame_id = frame_cnt_q + 32'd1;
			if (drop) begin
				res.verdict = ehp_pkg::VERDICT_OVERSIZE;
			end else if (fields.etype == ehp_pkg::ETYPE_IPV4) begin
				res.ip_kind = ehp_pkg::IP_V4;
				if (len_s1 < ehp_pkg::IPV4_MIN_LEN) begin
					res.verdict = ehp_pkg::VERDICT_TRUNCATED;
				end else begin
					res.verdict      = ehp_pkg::VERDICT_PASS;
					res.src_addr_low = {32'b0, fields.addr[223:192]};
					res.dst_addr_low = {32'b0, fields.addr[191:160]};
					proto            = fields.proto4;
				end
			end else if (fields.etype == ehp_pkg::ETYPE_IPV6) begin
				res.ip_kind = ehp_pkg::IP_V6;
				if (len_s1 < ehp_pkg::IPV6_MIN_LEN) begin
					res.verdict = ehp_pkg::VERDICT_TRUNCATED;
				end else begin
					res.verdict       = ehp_pkg::VERDICT_PASS;
					res.src_addr_high = fields.addr[255:192];
					res.src_addr_low  = fields.addr[191:128];
					res.dst_addr_high = fields.addr[127:64];
					res.dst_addr_low  = fields.addr[63:0];
					proto             = fields.proto6;
				end
			end else begin
				res.verdict = ehp_pkg::VERDICT_NOT_IP;
			end
			// Ports only when the transport header fits in the frame.
			if (res.verdict == ehp_pkg::VERDICT_PASS) begin
				if (proto == ehp_pkg::PROTO_TCP &&
					len_s1 >= toff16 + {8'b0, ehp_pkg::TCP_HDR_LEN}) begin
					res.transport_kind = ehp_pkg::TRANS_TCP;
					res.src_port       = fields.ports[31:16];
					res.dst_port       = fields.ports[15:0];
				end else if (proto == ehp_pkg::PROTO_UDP &&
					len_s1 >= toff16 + {8'b0, ehp_pkg::UDP_HDR_LEN}) begin
					res.transport_kind = ehp_pkg::TRANS_UDP;
					res.src_port       = fields.ports[31:16];
					res.dst_port       = fields.ports[15:0];
				end
			end
		end
	end

	// End-of-frame stage, counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_s1      <= 1'b0;
			frame_cnt_q <= 32'd0;
			ovs_cnt_q   <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				end_s1 <= frame_end.done;
			end
			if (end_s1 && move) begin
				out_valid_q <= 1'b1;
				if (!runt) begin
					frame_cnt_q <= frame_cnt_q + 32'd1;
					if (oversize) begin
						ovs_cnt_q <= ovs_inc;
					end
				end
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ready && frame_end.done) begin
			len_s1 <= frame_end.len;
		end
		if (end_s1 && move) begin
			out_q <= res;
		end
	end

	assign tx.valid          = out_valid_q;
	assign tx.verdict        = out_q.verdict;
	assign tx.ip_kind        = out_q.ip_kind;
	assign tx.transport_kind = out_q.transport_kind;
	assign tx.frame_id       = out_q.frame_id;
	assign tx.src_addr_high  = out_q.src_addr_high;
	assign tx.src_addr_low   = out_q.src_addr_low;
	assign tx.dst_addr_high  = out_q.dst_addr_high;
	assign tx.dst_addr_low   = out_q.dst_addr_low;
	assign tx.src_port       = out_q.src_port;
	assign tx.dst_port       = out_q.dst_port;
	assign tx.frame_length   = out_q.frame_length;

endmodule
`default_nettype wire

@@ hw/rtl/ethernet_ip_header_parser_core.sv @@
// Top level of the Ethernet/IPv4/IPv6 header parser.
//
// Frame bytes enter on rx, one byte per beat in wire order, with last_byte
// set on the final byte. Each frame yields exactly one result beat on tx,
// carrying the verdict, IP kind, addresses, transport ports, frame id and
// length. Header fields are captured at fixed byte positions, and ports at
// the transport offset, as the bytes stream in, so no frame buffer is needed.
// Throughput is one byte per cycle, back to back, across frame boundaries,
// while rx ready is high. The result reaches tx through the end-of-frame
// stage, which reads the captured fields, and then the output register.
// The end-of-frame stage and the output register together absorb one result
// while tx stalls; rx ready drops only when both hold a result and tx is
// not ready.
// Users must write configuration over the APB-style port only while the block is idle; not enforced.
// Reset clears the byte count, frame and oversize counters and the result
// valid flag, and loads max_frame_len = 1500 and oversize_limit = 100.
`timescale 1ns / 1ps
`default_nettype none
module ethernet_ip_header_parser_core #(
	parameter int unsigned MAX_FRAME_BYTES = 65535
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ehp_byte_if.sink         rx,
	ehp_result_if.source     tx,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	ehp_pkg::cfg_t        cfg;
	ehp_pkg::hdr_fields_t fields;
	ehp_pkg::frame_end_t  frame_end;
	logic                 in_ready;
	logic                 accept;

	assign rx.ready = in_ready;
	assign accept   = rx.valid & in_ready;

	// Configuration registers.
	ehp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Byte count and field capture.
	ehp_capture #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (rx.data_byte),
		.last_byte (rx.last_byte),
		.fields    (fields),
		.frame_end (frame_end)
	);

	// Verdict and result output.
	ehp_verdict u_verdict (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fields    (fields),
		.frame_end (frame_end),
		.in_ready  (in_ready),
		.tx        (tx)
	);

endmodule
`default_nettype wire
